FILE: rtl/dro_pkg.sv
// Shared types, codes and reset values for the dual range obstacle classifier.
`timescale 1ns / 1ps
`default_nettype none

package dro_pkg;

  localparam int unsigned DistW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    CLS_CLEAR   = 3'd0,
    CLS_LEFT    = 3'd1,
    CLS_RIGHT   = 3'd2,
    CLS_CENTER  = 3'd3,
    CLS_BOTH    = 3'd4,
    CLS_UNKNOWN = 3'd5
  } obs_class_e;

  typedef enum logic [1:0] {
    STEER_NONE        = 2'd0,
    STEER_AVOID_LEFT  = 2'd1,
    STEER_AVOID_RIGHT = 2'd2,
    STEER_HOLD        = 2'd3
  } steer_e;

  typedef enum logic [2:0] {
    ZONE_UNKNOWN   = 3'd0,
    ZONE_CLEAR     = 3'd1,
    ZONE_CAUTION   = 3'd2,
    ZONE_BLOCKED   = 3'd3,
    ZONE_EMERGENCY = 3'd4
  } zone_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_DISTANCE   = 3'd0,
    REG_MAX_DISTANCE   = 3'd1,
    REG_CENTER_BALANCE = 3'd2,
    REG_SIDE_MARGIN    = 3'd3,
    REG_STABLE_TIME    = 3'd4
  } reg_idx_e;

  localparam logic [CfgW-1:0] MinDistanceRst   = 16'd20;
  localparam logic [CfgW-1:0] MaxDistanceRst   = 16'd4000;
  localparam logic [CfgW-1:0] CenterBalanceRst = 16'd100;
  localparam logic [CfgW-1:0] SideMarginRst    = 16'd150;
  localparam logic [CfgW-1:0] StableTimeRst    = 16'd300;

  typedef struct packed {
    logic [DistW-1:0] min_distance_mm;
    logic [DistW-1:0] max_distance_mm;
    logic [DistW-1:0] center_balance_mm;
    logic [DistW-1:0] side_margin_mm;
    logic [CfgW-1:0]  stable_time_ms;
  } cfg_t;

  typedef struct packed {
    logic             fresh;
    logic             healthy;
    logic             echo_ok;
    logic [DistW-1:0] distance_mm;
    logic [2:0]       zone;
  } chan_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    chan_t            left;
    chan_t            right;
  } in_item_t;

  // Per-item scene verdict, before the persistence gate.
  typedef struct packed {
    logic       usable;
    obs_class_e cls;
    steer_e     steer;
  } scene_t;

endpackage

`default_nettype wire

FILE: rtl/dro_if.sv
// Valid/ready channel interfaces for update items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface dro_in_if;
  logic                         valid;
  logic                         ready;
  logic [dro_pkg::TimeW-1:0]    now_ms;
  logic                         left_fresh;
  logic                         left_healthy;
  logic                         left_echo_ok;
  logic [dro_pkg::DistW-1:0]    left_distance_mm;
  logic [2:0]                   left_zone;
  logic                         right_fresh;
  logic                         right_healthy;
  logic                         right_echo_ok;
  logic [dro_pkg::DistW-1:0]    right_distance_mm;
  logic [2:0]                   right_zone;

  modport source (
    output valid, now_ms, left_fresh, left_healthy, left_echo_ok, left_distance_mm,
           left_zone, right_fresh, right_healthy, right_echo_ok, right_distance_mm,
           right_zone,
    input  ready
  );
  modport sink (
    input  valid, now_ms, left_fresh, left_healthy, left_echo_ok, left_distance_mm,
           left_zone, right_fresh, right_healthy, right_echo_ok, right_distance_mm,
           right_zone,
    output ready
  );
endinterface

interface dro_out_if;
  logic                  valid;
  logic                  ready;
  dro_pkg::obs_class_e   obstacle_class;
  dro_pkg::steer_e       steer_decision;
  logic                  is_stable;

  modport source (
    output valid, obstacle_class, steer_decision, is_stable,
    input  ready
  );
  modport sink (
    input  valid, obstacle_class, steer_decision, is_stable,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/dro_scene.sv
// Channel usability check and scene classification for one update.
`timescale 1ns / 1ps
`default_nettype none

module dro_scene (
  input  dro_pkg::in_item_t item_i,
  input  dro_pkg::cfg_t     cfg_i,
  output dro_pkg::scene_t   scene_o
);

  logic                      l_ok, r_ok;
  logic                      l_blk, r_blk;
  logic                      l_stop, r_stop;
  logic [dro_pkg::DistW-1:0] ld, rd;
  logic [dro_pkg::DistW-1:0] l_minus_r, r_minus_l, diff;
  logic                      r_ge_l, l_ge_r;

  assign ld = item_i.left.distance_mm;
  assign rd = item_i.right.distance_mm;

  always_comb begin
    l_ok = item_i.left.fresh && item_i.left.healthy && item_i.left.echo_ok &&
           (ld >= cfg_i.min_distance_mm) && (ld <= cfg_i.max_distance_mm) &&
           (item_i.left.zone inside {dro_pkg::ZONE_CLEAR, dro_pkg::ZONE_CAUTION,
                                     dro_pkg::ZONE_BLOCKED, dro_pkg::ZONE_EMERGENCY});
    r_ok = item_i.right.fresh && item_i.right.healthy && item_i.right.echo_ok &&
           (rd >= cfg_i.min_distance_mm) && (rd <= cfg_i.max_distance_mm) &&
           (item_i.right.zone inside {dro_pkg::ZONE_CLEAR, dro_pkg::ZONE_CAUTION,
                                      dro_pkg::ZONE_BLOCKED, dro_pkg::ZONE_EMERGENCY});
    l_blk  = item_i.left.zone inside {dro_pkg::ZONE_CAUTION, dro_pkg::ZONE_BLOCKED,
                                      dro_pkg::ZONE_EMERGENCY};
    r_blk  = item_i.right.zone inside {dro_pkg::ZONE_CAUTION, dro_pkg::ZONE_BLOCKED,
                                       dro_pkg::ZONE_EMERGENCY};
    l_stop = item_i.left.zone inside {dro_pkg::ZONE_BLOCKED, dro_pkg::ZONE_EMERGENCY};
    r_stop = item_i.right.zone inside {dro_pkg::ZONE_BLOCKED, dro_pkg::ZONE_EMERGENCY};
  end

  assign r_ge_l    = rd >= ld;
  assign l_ge_r    = ld >= rd;
  assign r_minus_l = rd - ld;
  assign l_minus_r = ld - rd;
  assign diff      = r_ge_l ? r_minus_l : l_minus_r;

  always_comb begin
    scene_o.usable = l_ok && r_ok;
    scene_o.cls    = dro_pkg::CLS_CLEAR;
    scene_o.steer  = dro_pkg::STEER_NONE;
    case ({l_blk, r_blk})
      2'b10: begin
        scene_o.cls   = dro_pkg::CLS_LEFT;
        scene_o.steer = dro_pkg::STEER_AVOID_RIGHT;
      end
      2'b01: begin
        scene_o.cls   = dro_pkg::CLS_RIGHT;
        scene_o.steer = dro_pkg::STEER_AVOID_LEFT;
      end
      2'b11: begin
        scene_o.cls = (diff <= cfg_i.center_balance_mm) ? dro_pkg::CLS_CENTER
                                                         : dro_pkg::CLS_BOTH;
        // Right side is tried first, so it wins a tie at zero margin.
        if (r_ge_l && (r_minus_l >= cfg_i.side_margin_mm) && !r_stop) begin
          scene_o.steer = dro_pkg::STEER_AVOID_RIGHT;
        end else if (l_ge_r && (l_minus_r >= cfg_i.side_margin_mm) && !l_stop) begin
          scene_o.steer = dro_pkg::STEER_AVOID_LEFT;
        end else begin
          scene_o.steer = dro_pkg::STEER_HOLD;
        end
      end
      default: begin
        scene_o.cls   = dro_pkg::CLS_CLEAR;
        scene_o.steer = dro_pkg::STEER_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/dual_range_obstacle_classifier.sv
// Top level of the dual range obstacle classifier.
// Takes one update transaction per cycle unless a stalled result holds it back, and
// returns one result transaction per update. An accepted update is captured in the
// input register, then the scene check, candidate compare and 32-bit wrapping
// elapsed-time compare feed the result register, which drives the result valid.
// A full result register that is not taken stalls the pipeline, but one more update
// is still held in the input register. The persistence candidate is updated as each
// result is formed, so results follow update order exactly. Configuration writes take
// effect on the next clock and are meant to be made while no update is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dual_range_obstacle_classifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dro_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dro_pkg::CfgW-1:0]      cfg_data_i,
  dro_in_if.sink                             in_i,
  dro_out_if.source                          out_o
);

  dro_pkg::cfg_t     cfg_q;
  dro_pkg::in_item_t item_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              advance;

  dro_pkg::scene_t   scene;

  logic                       cand_present_q, cand_present_d;
  dro_pkg::obs_class_e        cand_cls_q, cand_cls_d;
  dro_pkg::steer_e            cand_steer_q, cand_steer_d;
  logic [dro_pkg::TimeW-1:0]  cand_start_q, cand_start_d;
  logic                       new_cand;
  logic [dro_pkg::TimeW-1:0]  start_eff, elapsed;
  logic                       gate_open;

  dro_pkg::obs_class_e        res_cls_q, res_cls_d;
  dro_pkg::steer_e            res_steer_q, res_steer_d;
  logic                       res_stable_q, res_stable_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance_mm   <= dro_pkg::MinDistanceRst;
      cfg_q.max_distance_mm   <= dro_pkg::MaxDistanceRst;
      cfg_q.center_balance_mm <= dro_pkg::CenterBalanceRst;
      cfg_q.side_margin_mm    <= dro_pkg::SideMarginRst;
      cfg_q.stable_time_ms    <= dro_pkg::StableTimeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dro_pkg::REG_MIN_DISTANCE:   cfg_q.min_distance_mm   <= cfg_data_i;
        dro_pkg::REG_MAX_DISTANCE:   cfg_q.max_distance_mm   <= cfg_data_i;
        dro_pkg::REG_CENTER_BALANCE: cfg_q.center_balance_mm <= cfg_data_i;
        dro_pkg::REG_SIDE_MARGIN:    cfg_q.side_margin_mm    <= cfg_data_i;
        dro_pkg::REG_STABLE_TIME:    cfg_q.stable_time_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register refills whenever it empties into the result stage.
  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.now_ms            <= in_i.now_ms;
      item_q.left.fresh        <= in_i.left_fresh;
      item_q.left.healthy      <= in_i.left_healthy;
      item_q.left.echo_ok      <= in_i.left_echo_ok;
      item_q.left.distance_mm  <= in_i.left_distance_mm;
      item_q.left.zone         <= in_i.left_zone;
      item_q.right.fresh       <= in_i.right_fresh;
      item_q.right.healthy     <= in_i.right_healthy;
      item_q.right.echo_ok     <= in_i.right_echo_ok;
      item_q.right.distance_mm <= in_i.right_distance_mm;
      item_q.right.zone        <= in_i.right_zone;
    end
  end

  dro_scene u_scene (
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .scene_o (scene)
  );

  // Persistence gate: a changed candidate restarts its timer at this update.
  assign new_cand  = !cand_present_q || (cand_cls_q != scene.cls) ||
                     (cand_steer_q != scene.steer);
  assign start_eff = new_cand ? item_q.now_ms : cand_start_q;
  assign elapsed   = item_q.now_ms - start_eff;
  assign gate_open = elapsed >= {{(dro_pkg::TimeW-dro_pkg::CfgW){1'b0}},
                                 cfg_q.stable_time_ms};

  always_comb begin
    cand_present_d = cand_present_q;
    cand_cls_d     = cand_cls_q;
    cand_steer_d   = cand_steer_q;
    cand_start_d   = cand_start_q;
    res_cls_d      = dro_pkg::CLS_UNKNOWN;
    res_steer_d    = dro_pkg::STEER_HOLD;
    res_stable_d   = 1'b0;
    if (!scene.usable) begin
      // Drop the candidate on any unusable channel.
      cand_present_d = 1'b0;
    end else begin
      if (new_cand) begin
        cand_present_d = 1'b1;
        cand_cls_d     = scene.cls;
        cand_steer_d   = scene.steer;
        cand_start_d   = item_q.now_ms;
      end
      res_cls_d    = scene.cls;
      res_steer_d  = gate_open ? scene.steer : dro_pkg::STEER_HOLD;
      res_stable_d = gate_open;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q      <= 1'b0;
      cand_present_q <= 1'b0;
      cand_cls_q     <= dro_pkg::CLS_CLEAR;
      cand_steer_q   <= dro_pkg::STEER_NONE;
      cand_start_q   <= '0;
    end else begin
      if (advance) begin
        out_vld_q      <= 1'b1;
        cand_present_q <= cand_present_d;
        cand_cls_q     <= cand_cls_d;
        cand_steer_q   <= cand_steer_d;
        cand_start_q   <= cand_start_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_cls_q    <= res_cls_d;
      res_steer_q  <= res_steer_d;
      res_stable_q <= res_stable_d;
    end
  end

  assign out_o.obstacle_class = res_cls_q;
  assign out_o.steer_decision = res_steer_q;
  assign out_o.is_stable      = res_stable_q;

endmodule

`default_nettype wire

FILE: rtl/dro_checker.sv
// Port-level assertions for the classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dro_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_class_i,
  input wire logic [1:0] out_steer_i,
  input wire logic       out_stable_i
);

  // An unknown scene never releases a decision.
  a_unknown_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_class_i == dro_pkg::CLS_UNKNOWN) |->
      (out_steer_i == dro_pkg::STEER_HOLD) && !out_stable_i)
    else $error("unknown class released a decision");

  // While the gate is closed the decision is held.
  a_gated_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stable_i |-> (out_steer_i == dro_pkg::STEER_HOLD))
    else $error("decision released before gate opened");

  // Class and decision pair up as the scene rules allow.
  a_side_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stable_i |->
      ((out_class_i == dro_pkg::CLS_CLEAR) && (out_steer_i == dro_pkg::STEER_NONE)) ||
      ((out_class_i == dro_pkg::CLS_LEFT) &&
       (out_steer_i == dro_pkg::STEER_AVOID_RIGHT)) ||
      ((out_class_i == dro_pkg::CLS_RIGHT) &&
       (out_steer_i == dro_pkg::STEER_AVOID_LEFT)) ||
      (((out_class_i == dro_pkg::CLS_CENTER) || (out_class_i == dro_pkg::CLS_BOTH)) &&
       (out_steer_i != dro_pkg::STEER_NONE)))
    else $error("released class and decision do not match");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_class_i) && $stable(out_steer_i) && $stable(out_stable_i))
    else $error("result changed while stalled");

endmodule

bind dual_range_obstacle_classifier dro_checker u_dro_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_class_i  (out_o.obstacle_class),
  .out_steer_i  (out_o.steer_decision),
  .out_stable_i (out_o.is_stable)
);

`default_nettype wire

FILE: test/tb_dual_range_obstacle_classifier.sv
// Randomized self-checking testbench for the dual range obstacle classifier.
`timescale 1ns / 1ps

module tb_dual_range_obstacle_classifier;
  import dro_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam logic [2:0] ZoneUndefMin = 3'd5;
  localparam logic [2:0] ZoneUndefMax = 3'd7;

  typedef struct packed {
    obs_class_e cls;
    steer_e     steer;
    logic       stable;
  } verdict_t;

  // Tracks the persistence candidate and the verdicts still owed by the block.
  class verdict_board;
    cfg_t        cfg;
    bit          cand_valid;
    obs_class_e  cand_cls;
    steer_e      cand_steer;
    logic [31:0] cand_start;
    verdict_t    verdict_q[$];
    int unsigned errors;

    function new();
      cfg.min_distance_mm   = MinDistanceRst;
      cfg.max_distance_mm   = MaxDistanceRst;
      cfg.center_balance_mm = CenterBalanceRst;
      cfg.side_margin_mm    = SideMarginRst;
      cfg.stable_time_ms    = StableTimeRst;
      cand_valid = 1'b0;
      cand_cls   = CLS_CLEAR;
      cand_steer = STEER_NONE;
      cand_start = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgW-1:0] val);
      case (idx)
        REG_MIN_DISTANCE:   cfg.min_distance_mm   = val;
        REG_MAX_DISTANCE:   cfg.max_distance_mm   = val;
        REG_CENTER_BALANCE: cfg.center_balance_mm = val;
        REG_SIDE_MARGIN:    cfg.side_margin_mm    = val;
        REG_STABLE_TIME:    cfg.stable_time_ms    = val;
        default: ;
      endcase
    endfunction

    function bit chan_usable(chan_t c);
      return c.fresh && c.healthy && c.echo_ok &&
             c.distance_mm >= cfg.min_distance_mm && c.distance_mm <= cfg.max_distance_mm &&
             c.zone >= ZONE_CLEAR && c.zone <= ZONE_EMERGENCY;
    endfunction

    function bit zone_blocks(logic [2:0] z);
      return z >= ZONE_CAUTION && z <= ZONE_EMERGENCY;
    endfunction

    function bit zone_stops(logic [2:0] z);
      return z == ZONE_BLOCKED || z == ZONE_EMERGENCY;
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    function void note_update(in_item_t it);
      verdict_t         v;
      obs_class_e       cls;
      steer_e           steer;
      logic [DistW-1:0] ld, rd, diff;
      logic [31:0]      elapsed;
      bit               lb, rb;
      ld = it.left.distance_mm;
      rd = it.right.distance_mm;
      if (!chan_usable(it.left) || !chan_usable(it.right)) begin
        cand_valid = 1'b0;
        v.cls    = CLS_UNKNOWN;
        v.steer  = STEER_HOLD;
        v.stable = 1'b0;
      end else begin
        lb = zone_blocks(it.left.zone);
        rb = zone_blocks(it.right.zone);
        if (lb && !rb) begin
          cls = CLS_LEFT;
          steer = STEER_AVOID_RIGHT;
        end else if (!lb && rb) begin
          cls = CLS_RIGHT;
          steer = STEER_AVOID_LEFT;
        end else if (!lb && !rb) begin
          cls = CLS_CLEAR;
          steer = STEER_NONE;
        end else begin
          diff = (ld > rd) ? ld - rd : rd - ld;
          if (diff <= cfg.center_balance_mm) cls = CLS_CENTER;
          else cls = CLS_BOTH;
          // right side is tried first, so a tie with zero margin goes right
          if (rd >= ld && rd - ld >= cfg.side_margin_mm && !zone_stops(it.right.zone))
            steer = STEER_AVOID_RIGHT;
          else if (ld >= rd && ld - rd >= cfg.side_margin_mm && !zone_stops(it.left.zone))
            steer = STEER_AVOID_LEFT;
          else
            steer = STEER_HOLD;
        end
        if (!cand_valid || cand_cls != cls || cand_steer != steer) begin
          cand_valid = 1'b1;
          cand_cls   = cls;
          cand_steer = steer;
          cand_start = it.now_ms;
        end
        elapsed = it.now_ms - cand_start;
        v.cls = cand_cls;
        if (elapsed >= {16'd0, cfg.stable_time_ms}) begin
          v.steer  = cand_steer;
          v.stable = 1'b1;
        end else begin
          v.steer  = STEER_HOLD;
          v.stable = 1'b0;
        end
      end
      verdict_q.push_back(v);
    endfunction

    function void check_result(obs_class_e cls, steer_e steer, logic stable);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("result transaction with no update pending: class %0d steer %0d stable %0b",
               cls, steer, stable);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (cls !== v.cls) begin
        $error("obstacle_class: expected %0d, actual %0d", v.cls, cls);
        errors++;
      end
      if (steer !== v.steer) begin
        $error("steer_decision: expected %0d, actual %0d", v.steer, steer);
        errors++;
      end
      if (stable !== v.stable) begin
        $error("is_stable: expected %0b, actual %0b", v.stable, stable);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = REG_MIN_DISTANCE;
  logic [CfgW-1:0]     cfg_data_i = '0;
  bit                  steady_flow = 1'b0;
  verdict_board        sb = new();

  dro_in_if  upd_if ();
  dro_out_if res_if ();

  dual_range_obstacle_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (upd_if),
    .out_o      (res_if)
  );

  always #6 clk_i = ~clk_i;

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t scene(logic [31:0] now, logic [DistW-1:0] ld, logic [2:0] lz,
                                     logic [DistW-1:0] rd, logic [2:0] rz);
    in_item_t it;
    it.now_ms = now;
    it.left  = '{fresh: 1'b1, healthy: 1'b1, echo_ok: 1'b1, distance_mm: ld, zone: lz};
    it.right = '{fresh: 1'b1, healthy: 1'b1, echo_ok: 1'b1, distance_mm: rd, zone: rz};
    return it;
  endfunction

  // Usable readings on both sides under the current limits, unless the limits are inverted.
  function automatic in_item_t random_scene();
    in_item_t it;
    int       lo, hi, d, off;
    lo = sb.cfg.min_distance_mm;
    hi = sb.cfg.max_distance_mm;
    it = scene('0, 16'($urandom_range(hi, lo)),
               3'($urandom_range(int'(ZONE_CLEAR), int'(ZONE_EMERGENCY))),
               16'($urandom_range(hi, lo)),
               3'($urandom_range(int'(ZONE_CLEAR), int'(ZONE_EMERGENCY))));
    case ($urandom_range(0, 3))
      0: it.right.distance_mm = it.left.distance_mm;
      1: begin
        // keep the sides close so balance and margin decide
        off = $urandom_range(0, 2 * (int'(sb.cfg.side_margin_mm) +
                                     int'(sb.cfg.center_balance_mm)) + 2);
        d = int'(it.left.distance_mm) + ($urandom_range(0, 1) ? off : -off);
        if (d < lo) d = lo;
        if (d > hi) d = hi;
        it.right.distance_mm = d[DistW-1:0];
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic in_item_t corrupt(in_item_t it);
    case ($urandom_range(0, 4))
      0: begin
        it.left.fresh   = 1'($urandom_range(0, 1));
        it.left.healthy = 1'($urandom_range(0, 1));
        it.left.echo_ok = 1'($urandom_range(0, 1));
      end
      1: begin
        it.right.fresh   = 1'($urandom_range(0, 1));
        it.right.healthy = 1'($urandom_range(0, 1));
        it.right.echo_ok = 1'($urandom_range(0, 1));
      end
      2: begin
        it.left.distance_mm  = 16'($urandom());
        it.right.distance_mm = 16'($urandom());
      end
      3: begin
        it.left.zone  = 3'($urandom_range(int'(ZONE_UNKNOWN), int'(ZoneUndefMax)));
        it.right.zone = 3'($urandom_range(int'(ZONE_UNKNOWN), int'(ZoneUndefMax)));
      end
      default: begin
        it.left.distance_mm  = sb.cfg.min_distance_mm - 16'd1;
        it.right.distance_mm = sb.cfg.max_distance_mm + 16'd1;
      end
    endcase
    return it;
  endfunction

  // Returns at the edge where the transaction is taken; valid stays up for the next one.
  task automatic send_update(in_item_t it);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      upd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    upd_if.valid             <= 1'b1;
    upd_if.now_ms            <= it.now_ms;
    upd_if.left_fresh        <= it.left.fresh;
    upd_if.left_healthy      <= it.left.healthy;
    upd_if.left_echo_ok      <= it.left.echo_ok;
    upd_if.left_distance_mm  <= it.left.distance_mm;
    upd_if.left_zone         <= it.left.zone;
    upd_if.right_fresh       <= it.right.fresh;
    upd_if.right_healthy     <= it.right.healthy;
    upd_if.right_echo_ok     <= it.right.echo_ok;
    upd_if.right_distance_mm <= it.right.distance_mm;
    upd_if.right_zone        <= it.right.zone;
    @(posedge clk_i);
    while (!upd_if.ready) @(posedge clk_i);
    sb.note_update(it);
  endtask

  task automatic drain();
    upd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_MIN_DISTANCE, c.min_distance_mm);
    write_reg(REG_MAX_DISTANCE, c.max_distance_mm);
    write_reg(REG_CENTER_BALANCE, c.center_balance_mm);
    write_reg(REG_SIDE_MARGIN, c.side_margin_mm);
    write_reg(REG_STABLE_TIME, c.stable_time_ms);
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t phase_config(int p);
    cfg_t c;
    case (p)
      0: begin
        c.min_distance_mm   = 16'd0;
        c.max_distance_mm   = 16'hFFFF;
        c.center_balance_mm = 16'($urandom_range(0, 3000));
        c.side_margin_mm    = 16'($urandom_range(0, 3000));
        c.stable_time_ms    = 16'($urandom_range(0, 500));
      end
      1: begin
        // only the top distance is usable
        c.min_distance_mm   = 16'hFFFF;
        c.max_distance_mm   = 16'hFFFF;
        c.center_balance_mm = 16'd0;
        c.side_margin_mm    = 16'd0;
        c.stable_time_ms    = 16'd0;
      end
      2: begin
        c.min_distance_mm   = 16'($urandom_range(1000, 65535));
        c.max_distance_mm   = 16'($urandom_range(0, c.min_distance_mm - 1));
        c.center_balance_mm = 16'($urandom_range(0, 65535));
        c.side_margin_mm    = 16'($urandom_range(0, 65535));
        c.stable_time_ms    = 16'($urandom_range(0, 65535));
      end
      3: begin
        c.min_distance_mm   = 16'd0;
        c.max_distance_mm   = 16'($urandom_range(1000, 65535));
        c.center_balance_mm = 16'hFFFF;
        c.side_margin_mm    = 16'hFFFF;
        c.stable_time_ms    = 16'hFFFF;
      end
      default: begin
        c.min_distance_mm   = 16'($urandom_range(0, 1000));
        c.max_distance_mm   = 16'($urandom_range(65535, c.min_distance_mm));
        c.center_balance_mm = 16'($urandom_range(0, 1000));
        c.side_margin_mm    = 16'($urandom_range(0, 1000));
        c.stable_time_ms    = 16'($urandom_range(0, 1000));
      end
    endcase
    return c;
  endfunction

  // Hold each scene for a few updates so candidates get the chance to settle.
  task automatic random_phase(int unsigned count);
    in_item_t    it;
    logic [31:0] now;
    int unsigned hold_cnt, step_max;
    now = $urandom();
    hold_cnt = 0;
    step_max = sb.cfg.stable_time_ms / 4 + 3;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      if (hold_cnt == 0) begin
        it = random_scene();
        hold_cnt = $urandom_range(1, 12);
      end
      hold_cnt--;
      if ($urandom_range(0, 99) < 5) now = $urandom();
      else now += $urandom_range(0, step_max);
      it.now_ms = now;
      if ($urandom_range(0, 99) < 15) send_update(corrupt(it));
      else send_update(it);
    end
    steady_flow = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall, run;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_len();
      run = $urandom_range(1, 30);
      repeat (stall) begin
        res_if.ready <= 1'b0;
        @(posedge clk_i);
      end
      repeat (run) begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready)
        sb.check_result(res_if.obstacle_class, res_if.steer_decision, res_if.is_stable);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    in_item_t it;
    cfg_t     c;
    upd_if.valid             <= 1'b0;
    upd_if.now_ms            <= '0;
    upd_if.left_fresh        <= 1'b0;
    upd_if.left_healthy      <= 1'b0;
    upd_if.left_echo_ok      <= 1'b0;
    upd_if.left_distance_mm  <= '0;
    upd_if.left_zone         <= ZONE_UNKNOWN;
    upd_if.right_fresh       <= 1'b0;
    upd_if.right_healthy     <= 1'b0;
    upd_if.right_echo_ok     <= 1'b0;
    upd_if.right_distance_mm <= '0;
    upd_if.right_zone        <= ZONE_UNKNOWN;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flags, limits and zone codes that make a channel unusable
    it = scene(32'd1000, 16'd500, ZONE_CLEAR, 16'd500, ZONE_CLEAR);
    it.left.fresh = 1'b0;
    send_update(it);
    it = scene(32'd1000, 16'd500, ZONE_CLEAR, 16'd500, ZONE_CLEAR);
    it.left.healthy = 1'b0;
    send_update(it);
    it = scene(32'd1000, 16'd500, ZONE_CLEAR, 16'd500, ZONE_CLEAR);
    it.right.echo_ok = 1'b0;
    send_update(it);
    send_update(scene(32'd1000, 16'd19, ZONE_CLEAR, 16'd500, ZONE_CLEAR));
    send_update(scene(32'd1000, 16'd500, ZONE_CLEAR, 16'd4001, ZONE_CLEAR));
    send_update(scene(32'd1000, 16'd500, ZONE_UNKNOWN, 16'd500, ZONE_CLEAR));
    send_update(scene(32'd1000, 16'd500, ZONE_CLEAR, 16'd500, ZoneUndefMax));
    send_update(scene(32'd1000, 16'd500, ZoneUndefMin, 16'd500, ZONE_CLEAR));
    // clear scene at the limits, then walk the gate up to release
    send_update(scene(32'd1000, 16'd20, ZONE_CLEAR, 16'd4000, ZONE_CLEAR));
    send_update(scene(32'd1299, 16'd20, ZONE_CLEAR, 16'd4000, ZONE_CLEAR));
    send_update(scene(32'd1300, 16'd20, ZONE_CLEAR, 16'd4000, ZONE_CLEAR));
    // every class and decision
    send_update(scene(32'd1300, 16'd800, ZONE_CAUTION, 16'd900, ZONE_CLEAR));
    send_update(scene(32'd1400, 16'd800, ZONE_CLEAR, 16'd900, ZONE_BLOCKED));
    send_update(scene(32'd1500, 16'd1000, ZONE_CAUTION, 16'd1050, ZONE_CAUTION));
    send_update(scene(32'd1600, 16'd1000, ZONE_CAUTION, 16'd1200, ZONE_CAUTION));
    send_update(scene(32'd1900, 16'd1000, ZONE_CAUTION, 16'd1200, ZONE_CAUTION));
    send_update(scene(32'd2000, 16'd1300, ZONE_CAUTION, 16'd1000, ZONE_EMERGENCY));
    send_update(scene(32'd2100, 16'd1000, ZONE_BLOCKED, 16'd2000, ZONE_EMERGENCY));
    // elapsed time across the 32-bit wrap
    send_update(scene(32'hFFFF_FF00, 16'd600, ZONE_CLEAR, 16'd600, ZONE_CLEAR));
    send_update(scene(32'h0000_0030, 16'd600, ZONE_CLEAR, 16'd600, ZONE_CLEAR));
    send_update(scene(32'h0000_0040, 16'd0, ZONE_CAUTION, 16'hFFFF, ZONE_CAUTION));
    drain();

    // zero margin, zero balance, no gate, full distance range
    c = '{min_distance_mm: 16'd0, max_distance_mm: 16'hFFFF, center_balance_mm: 16'd0,
          side_margin_mm: 16'd0, stable_time_ms: 16'd0};
    apply_config(c);
    send_update(scene(32'd5, 16'd500, ZONE_CAUTION, 16'd500, ZONE_CAUTION));
    send_update(scene(32'd6, 16'd0, ZONE_CAUTION, 16'hFFFF, ZONE_BLOCKED));
    drain();

    // inverted limits accept nothing
    c = '{min_distance_mm: 16'd100, max_distance_mm: 16'd99, center_balance_mm: 16'd100,
          side_margin_mm: 16'd150, stable_time_ms: 16'd300};
    apply_config(c);
    send_update(scene(32'd7, 16'd100, ZONE_CLEAR, 16'd99, ZONE_CLEAR));
    drain();

    for (int p = 0; p < 9; p++) begin
      apply_config(phase_config(p));
      random_phase((p == 2) ? 100 : 250);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
